@@ rtl/gas_pkg.sv @@
// Package: sizes, codes and types shared by the alignment score block.
package gas_pkg;

  localparam int SEQ_LEN   = 16;
  localparam int CHAR_W    = 8;
  localparam int CFG_W     = 5;
  localparam int IDX_W     = 2;
  localparam int OUT_W     = 11;
  localparam int SCORE_W   = 12;
  localparam int CNT_W     = $clog2(SEQ_LEN);
  localparam int STEP_W    = $clog2(2 * SEQ_LEN);
  localparam int NUM_STEPS = 2 * SEQ_LEN - 1;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_MATCH    = 2'd0;
  localparam logic [IDX_W-1:0] REG_MISMATCH = 2'd1;
  localparam logic [IDX_W-1:0] REG_GAP      = 2'd2;

  // Register reset values
  localparam logic signed [CFG_W-1:0] MATCH_RST    = 5'sd1;
  localparam logic signed [CFG_W-1:0] MISMATCH_RST = -5'sd1;
  localparam logic signed [CFG_W-1:0] GAP_RST      = -5'sd2;

  typedef enum logic [1:0] {
    S_LOAD,
    S_CALC,
    S_EMIT
  } gas_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic              load;
    logic              init;
    logic              step;
    logic              capture;
    logic [STEP_W-1:0] step_idx;
  } gas_cmd_t;

endpackage

@@ rtl/gas_if.sv @@
// Interfaces: input, result and configuration channels.
interface gas_in_if;
  import gas_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] query_char;
  logic [CHAR_W-1:0] subject_char;
  modport source (output valid, output query_char, output subject_char, input ready);
  modport sink   (input valid, input query_char, input subject_char, output ready);
endinterface

interface gas_out_if;
  import gas_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] alignment_score;
  modport source (output valid, output alignment_score, input ready);
  modport sink   (input valid, input alignment_score, output ready);
endinterface

interface gas_cfg_if;
  import gas_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [CFG_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/gas_ctrl.sv @@
// Controller: load counter, wavefront step counter and result handshake.
module gas_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output gas_pkg::gas_cmd_t cmd
);
  import gas_pkg::*;

  gas_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [STEP_W-1:0] st_r, st_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              in_acc;
  logic              last_load;
  logic              slot_free;

  assign in_acc    = in_valid && in_ready;
  assign last_load = in_acc && (cnt_r == CNT_W'(SEQ_LEN - 1));
  assign slot_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: if (last_load) state_nxt = S_CALC;
      S_CALC: if (st_r == STEP_W'(NUM_STEPS)) state_nxt = S_EMIT;
      S_EMIT: if (slot_free) state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
  end

  // Outputs and counters
  always_comb begin
    in_ready     = (state_r == S_LOAD);
    cmd.load     = in_acc;
    cmd.init     = last_load;
    cmd.step     = (state_r == S_CALC);
    cmd.capture  = (state_r == S_EMIT) && slot_free;
    cmd.step_idx = st_r;
    cnt_nxt      = cnt_r;
    st_nxt       = st_r;
    if (in_acc) begin
      cnt_nxt = last_load ? '0 : cnt_r + CNT_W'(1);
    end
    if (last_load) begin
      st_nxt = STEP_W'(1);
    end else if (state_r == S_CALC) begin
      st_nxt = st_r + STEP_W'(1);
    end
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.capture) out_valid_nxt = 1'b1;
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_load_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !in_ready)
    else $error("input taken during wavefront");
  a_last_starts_calc: assert property (@(posedge clk) disable iff (!rst_n)
    last_load |=> (state_r == S_CALC) && (st_r == STEP_W'(1)))
    else $error("last item did not start wavefront");
  a_capture_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> out_valid_r && (state_r == S_LOAD))
    else $error("captured result not presented");
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CALC) |-> (st_r >= STEP_W'(1)) && (st_r <= STEP_W'(NUM_STEPS)))
    else $error("step counter out of range");
`endif

endmodule

@@ rtl/gas_dpath.sv @@
// Datapath: sequence shift lines, score registers, row of wavefront cells.
module gas_dpath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  gas_pkg::gas_cmd_t                cmd,
  input  logic [gas_pkg::CHAR_W-1:0]       query_char,
  input  logic [gas_pkg::CHAR_W-1:0]       subject_char,
  input  logic                             cfg_we,
  input  logic [gas_pkg::IDX_W-1:0]        cfg_index,
  input  logic [gas_pkg::CFG_W-1:0]        cfg_data,
  output logic signed [gas_pkg::OUT_W-1:0] alignment_score
);
  import gas_pkg::*;

  localparam logic signed [SCORE_W-1:0] SAT_HI = SCORE_W'(1023);
  localparam logic signed [SCORE_W-1:0] SAT_LO = -SCORE_W'(1024);

  logic signed [CFG_W-1:0]   match_r, mismatch_r, gap_r;
  logic signed [SCORE_W-1:0] match_x, mismatch_x, gap_x;
  logic [CHAR_W-1:0]         s_r [SEQ_LEN];
  logic [CHAR_W-1:0]         ql_r [SEQ_LEN];
  logic [CHAR_W-1:0]         q_r [SEQ_LEN-1];
  logic [CHAR_W-1:0]         qin [SEQ_LEN];
  logic signed [SCORE_W-1:0] h_r [SEQ_LEN];
  logic signed [SCORE_W-1:0] hp_r [SEQ_LEN];
  logic signed [SCORE_W-1:0] b_r;
  logic signed [SCORE_W-1:0] corner;
  logic signed [OUT_W-1:0]   res_r;

  assign match_x    = SCORE_W'(match_r);
  assign mismatch_x = SCORE_W'(mismatch_r);
  assign gap_x      = SCORE_W'(gap_r);

  // Score registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r    <= MATCH_RST;
      mismatch_r <= MISMATCH_RST;
      gap_r      <= GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MATCH:    match_r    <= cfg_data;
        REG_MISMATCH: mismatch_r <= cfg_data;
        REG_GAP:      gap_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Shift in sequences; stream query into the first cell during steps
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < SEQ_LEN - 1; k++) begin
        s_r[k]  <= s_r[k+1];
        ql_r[k] <= ql_r[k+1];
      end
      s_r[SEQ_LEN-1]  <= subject_char;
      ql_r[SEQ_LEN-1] <= query_char;
    end else if (cmd.step) begin
      for (int k = 0; k < SEQ_LEN - 1; k++) begin
        ql_r[k] <= ql_r[k+1];
      end
    end
  end

  // Left boundary column: holds (step-1) * gap
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      b_r <= '0;
    end else if (cmd.step) begin
      b_r <= b_r + gap_x;
    end
  end

  assign qin[0] = ql_r[0];

  // Row of cells, one per matrix column
  for (genvar p = 0; p < SEQ_LEN; p++) begin : g_cell
    localparam logic signed [SCORE_W-1:0] COL = SCORE_W'(p + 1);
    logic                      act;
    logic signed [SCORE_W-1:0] diag, left, sub, c_d, c_u, c_l, m_du, best;

    if (p > 0) begin : g_q
      assign qin[p] = q_r[p-1];
    end
    if (p < SEQ_LEN - 1) begin : g_qr
      always_ff @(posedge clk) begin
        if (cmd.step) q_r[p] <= qin[p];
      end
    end

    if (p == 0) begin : g_edge
      assign diag = b_r;
      assign left = b_r + gap_x;
    end else begin : g_mid
      assign diag = hp_r[p-1];
      assign left = h_r[p-1];
    end

    assign act  = cmd.step && (cmd.step_idx >= STEP_W'(p + 1)) &&
                  (cmd.step_idx <= STEP_W'(p + SEQ_LEN));
    assign sub  = (qin[p] == s_r[p]) ? match_x : mismatch_x;
    assign c_d  = diag + sub;
    assign c_u  = h_r[p] + gap_x;
    assign c_l  = left + gap_x;
    assign m_du = (c_d > c_u) ? c_d : c_u;
    assign best = (m_du > c_l) ? m_du : c_l;

    // Seed with the top boundary row, then advance while the cell is active
    always_ff @(posedge clk) begin
      if (cmd.init) begin
        h_r[p] <= SCORE_W'(COL * gap_x);
      end else if (act) begin
        h_r[p]  <= best;
        hp_r[p] <= h_r[p];
      end
    end
  end

  // Saturate and hold the corner score
  assign corner = h_r[SEQ_LEN-1];
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      priority if (corner > SAT_HI) res_r <= OUT_W'(SAT_HI);
      else if (corner < SAT_LO)     res_r <= OUT_W'(SAT_LO);
      else                          res_r <= OUT_W'(corner);
    end
  end

  assign alignment_score = res_r;

endmodule

@@ rtl/global_alignment_score_top.sv @@
// Top level: global alignment score, controller plus wavefront datapath.
//
//  channel  | dir | handshake     | payload
//  in_ch    | in  | valid/ready   | query_char[7:0], subject_char[7:0]
//  out_ch   | out | valid/ready   | alignment_score[10:0] signed
//  cfg_ch   | in  | valid/ready=1 | index[1:0], data[4:0]
//
// Sixteen items load one per cycle while valid is held; the last starts a 31-step
// wavefront over the row of sixteen cells, then the corner score is captured
// once the output register is free.
// Reset (rst_n low, synchronous) clears the counters and restores the scores.
// A waiting result sits in the output register while the next pair loads;
// only a second finished result waits for it to be taken.
module global_alignment_score_top (
  input  logic      clk,
  input  logic      rst_n,
  gas_in_if.sink    in_ch,
  gas_out_if.source out_ch,
  gas_cfg_if.sink   cfg_ch
);
  import gas_pkg::*;

  gas_cmd_t cmd;

  assign cfg_ch.ready = 1'b1;

  gas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  gas_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .query_char      (in_ch.query_char),
    .subject_char    (in_ch.subject_char),
    .cfg_we          (cfg_ch.valid),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .alignment_score (out_ch.alignment_score)
  );

endmodule

@@ tb/sv/global_alignment_score_top_tb.sv @@
// Testbench for the global alignment score block, self-checking against a scoring model.
`timescale 1ns / 1ps

module global_alignment_score_top_tb;
  import gas_pkg::*;

  // Unmapped register index: writes to it are dropped
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 64;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SCORE_MIN = -1024;
  localparam int SCORE_MAX = 1023;

  typedef enum {
    SEQ_RANDOM,
    SEQ_FEW_LETTERS,
    SEQ_IDENTICAL,
    SEQ_SHIFTED,
    SEQ_UNIFORM
  } seq_kind_t;

  logic clk;
  logic rst_n;
  bit   idling_on;
  int   error_count;

  gas_in_if  in_ch ();
  gas_out_if out_ch ();
  gas_cfg_if cfg_ch ();

  global_alignment_score_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Scoring model state: stored sequences, fill count, score registers
  logic [CHAR_W-1:0]       query_seq   [SEQ_LEN];
  logic [CHAR_W-1:0]       subject_seq [SEQ_LEN];
  int                      pairs_loaded;
  logic signed [CFG_W-1:0] match_reg;
  logic signed [CFG_W-1:0] mismatch_reg;
  logic signed [CFG_W-1:0] gap_reg;
  logic signed [OUT_W-1:0] pending_scores [$];

  // Fill the score matrix row by row and return the saturated corner
  function automatic logic signed [OUT_W-1:0] nw_corner_score();
    int row [0:SEQ_LEN];
    int diag;
    int up;
    int best;
    int m;
    int mm;
    int g;
    m  = int'(match_reg);
    mm = int'(mismatch_reg);
    g  = int'(gap_reg);
    for (int j = 0; j <= SEQ_LEN; j++) row[j] = j * g;
    for (int i = 1; i <= SEQ_LEN; i++) begin
      diag   = row[0];
      row[0] = i * g;
      for (int j = 1; j <= SEQ_LEN; j++) begin
        up   = row[j];
        best = diag + ((query_seq[i-1] == subject_seq[j-1]) ? m : mm);
        if (up + g > best) best = up + g;
        if (row[j-1] + g > best) best = row[j-1] + g;
        row[j] = best;
        diag   = up;
      end
    end
    best = row[SEQ_LEN];
    if (best < SCORE_MIN) best = SCORE_MIN;
    if (best > SCORE_MAX) best = SCORE_MAX;
    return OUT_W'(best);
  endfunction

  // Store one accepted pair; the last of a round produces a score
  function automatic void store_pair(logic [CHAR_W-1:0] q, logic [CHAR_W-1:0] s);
    if (pairs_loaded >= SEQ_LEN) pairs_loaded = 0;
    query_seq[pairs_loaded]   = q;
    subject_seq[pairs_loaded] = s;
    pairs_loaded++;
    if (pairs_loaded == SEQ_LEN) begin
      pairs_loaded = 0;
      pending_scores.push_back(nw_corner_score());
    end
  endfunction

  // Send one pair, with an optional gap first; predict on acceptance
  task automatic send_pair(logic [CHAR_W-1:0] q, logic [CHAR_W-1:0] s);
    @(negedge clk);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.query_char   <= q;
    in_ch.subject_char <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    store_pair(q, s);
  endtask

  // Build one round of sequences of the given kind and send it
  task automatic send_round(seq_kind_t kind);
    logic [CHAR_W-1:0] q [SEQ_LEN];
    logic [CHAR_W-1:0] s [SEQ_LEN];
    logic [CHAR_W-1:0] letters [4];
    logic [CHAR_W-1:0] base [SEQ_LEN + 4];
    int shift;
    foreach (letters[k]) letters[k] = CHAR_W'($urandom_range(0, 255));
    foreach (base[k]) base[k] = letters[$urandom_range(0, 3)];
    shift = $urandom_range(1, 3);
    for (int i = 0; i < SEQ_LEN; i++) begin
      case (kind)
        SEQ_RANDOM: begin
          q[i] = CHAR_W'($urandom_range(0, 255));
          s[i] = CHAR_W'($urandom_range(0, 255));
        end
        SEQ_FEW_LETTERS: begin
          q[i] = letters[$urandom_range(0, 3)];
          s[i] = letters[$urandom_range(0, 3)];
        end
        SEQ_IDENTICAL: begin
          q[i] = base[i];
          s[i] = base[i];
        end
        SEQ_SHIFTED: begin
          // subject is the query slid by a few places, with the odd point change
          q[i] = base[i];
          s[i] = ($urandom_range(0, 7) == 0) ? letters[$urandom_range(0, 3)] : base[i + shift];
        end
        default: begin
          q[i] = letters[0];
          s[i] = letters[1];
        end
      endcase
    end
    for (int i = 0; i < SEQ_LEN; i++) send_pair(q[i], s[i]);
  endtask

  // Drop the input valid and wait until the block has gone quiet
  task automatic quiesce();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; the caller drops the valid afterwards
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_MATCH:    match_reg    = data;
      REG_MISMATCH: mismatch_reg = data;
      REG_GAP:      gap_reg      = data;
      default: ;
    endcase
  endtask

  task automatic set_scores(int m, int mm, int g);
    quiesce();
    write_reg(REG_MATCH, CFG_W'(m));
    write_reg(REG_MISMATCH, CFG_W'(mm));
    write_reg(REG_GAP, CFG_W'(g));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Reset scores; field extremes and equal/unequal bytes in one round
  task automatic test_reset_scores();
    logic [CHAR_W-1:0] q [SEQ_LEN] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h80, 8'h7F,
                                       8'h01, 8'hFE, 8'h10, 8'hEF, 8'h33, 8'hCC, 8'h0F, 8'hF0};
    logic [CHAR_W-1:0] s [SEQ_LEN] = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h55, 8'h55, 8'h80, 8'h80,
                                       8'h01, 8'h01, 8'hEF, 8'hEF, 8'hCC, 8'hCC, 8'hF0, 8'hF0};
    for (int i = 0; i < SEQ_LEN; i++) send_pair(q[i], s[i]);
  endtask

  // Register extremes, plus a write to the unmapped index
  task automatic test_score_extremes();
    int ext_m  [7] = '{15, -15, -16, 15, 0, 15, -16};
    int ext_mm [7] = '{-15, 15, -16, 15, 0, -16, 15};
    int ext_g  [7] = '{-15, 15, -16, 15, 0, 0, -16};
    for (int p = 0; p < 7; p++) begin
      set_scores(ext_m[p], ext_mm[p], ext_g[p]);
      send_round(SEQ_IDENTICAL);
      send_round(SEQ_FEW_LETTERS);
    end
    quiesce();
    write_reg(REG_SPARE, CFG_W'($urandom_range(0, 31)));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    send_round(SEQ_SHIFTED);
    send_round(SEQ_UNIFORM);
  endtask

  // Random settings, each phase a few rounds of mixed sequence kinds
  task automatic test_random_settings();
    for (int p = 0; p < 12; p++) begin
      set_scores($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
      idling_on = (p % 3 != 2);
      for (int r = 0; r < 4; r++) send_round(seq_kind_t'($urandom_range(0, 4)));
    end
  endtask

  // Final stretch: no gaps on either side
  task automatic test_back_to_back();
    set_scores($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
    idling_on = 1'b0;
    for (int r = 0; r < 13; r++) send_round(seq_kind_t'($urandom_range(0, 4)));
  endtask

  // Result side: random stall bursts on ready
  initial begin : ready_driver
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted score with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_scores.size() == 0) begin
        $display("%0t: unexpected score, expected none, actual %0d", $time,
                 out_ch.alignment_score);
        error_count++;
      end else if (out_ch.alignment_score !== pending_scores[0]) begin
        $display("%0t: score mismatch, expected %0d, actual %0d", $time,
                 pending_scores[0], out_ch.alignment_score);
        error_count++;
        void'(pending_scores.pop_front());
      end else begin
        void'(pending_scores.pop_front());
      end
    end
  end

  // Watchdog: end the run after too long without any handshake
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
          || (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: timeout, %0d scores still pending", $time, pending_scores.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_n              = 1'b0;
    idling_on          = 1'b1;
    error_count        = 0;
    pairs_loaded       = 0;
    match_reg          = MATCH_RST;
    mismatch_reg       = MISMATCH_RST;
    gap_reg            = GAP_RST;
    in_ch.valid        = 1'b0;
    in_ch.query_char   = '0;
    in_ch.subject_char = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_MATCH;
    cfg_ch.data        = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_scores();
    test_score_extremes();
    test_random_settings();
    test_back_to_back();
    quiesce();

    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/gas_pkg.sv
rtl/gas_if.sv
rtl/gas_ctrl.sv
rtl/gas_dpath.sv
rtl/global_alignment_score_top.sv
tb/sv/global_alignment_score_top_tb.sv
